// ===== sv/lifeb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifeb_pkg
// shared types and codes of the life board engine: request codes, register
// indexes, rule constants, controller states and the command and status groups
// ----------------------------------------------------------------------------
package lifeb_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_RUN   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_USED = 1'd1;

    // rule constants
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_CELL_WR,
        ST_GEN_PRIME,
        ST_GEN_SWEEP,
        ST_GEN_CHECK,
        ST_RESP
    } lifeb_state_t;

    typedef struct packed {
        logic load_req;    // latch the accepted item
        logic mem_rd_req;  // read the addressed row
        logic cell_wr;     // write back the addressed row with one cell changed
        logic gen_prime;   // start a generation sweep
        logic gen_step;    // one row of the sweep
        logic gen_dec;     // one generation done
        logic out_load;    // load the result register
    } lifeb_cmd_t;

    typedef struct packed {
        logic is_run;
        logic is_write;
        logic gen_zero;
        logic gen_last;
        logic sweep_last;
        logic changed;
        logic out_busy;
    } lifeb_status_t;

endpackage

// ===== sv/lifeb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifeb_ctrl
// request sequencer: accepts an item, steps the datapath through cell access
// or generation sweeps, and hands the result to the output register
// ----------------------------------------------------------------------------
module lifeb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  lifeb_pkg::lifeb_status_t status,
    output lifeb_pkg::lifeb_cmd_t    cmd
);

    lifeb_pkg::lifeb_state_t state_reg;
    lifeb_pkg::lifeb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lifeb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lifeb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lifeb_pkg::ST_ACCESS;
                end
            end
            lifeb_pkg::ST_ACCESS:
            begin
                if (status.is_run && !status.gen_zero)
                begin
                    state_next = lifeb_pkg::ST_GEN_PRIME;
                end
                else if (status.is_write)
                begin
                    state_next = lifeb_pkg::ST_CELL_WR;
                end
                else
                begin
                    state_next = lifeb_pkg::ST_RESP;
                end
            end
            lifeb_pkg::ST_CELL_WR:
            begin
                state_next = lifeb_pkg::ST_RESP;
            end
            lifeb_pkg::ST_GEN_PRIME:
            begin
                state_next = lifeb_pkg::ST_GEN_SWEEP;
            end
            lifeb_pkg::ST_GEN_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    state_next = lifeb_pkg::ST_GEN_CHECK;
                end
            end
            lifeb_pkg::ST_GEN_CHECK:
            begin
                // a board that did not change stays that way
                if (!status.changed || status.gen_last)
                begin
                    state_next = lifeb_pkg::ST_RESP;
                end
                else
                begin
                    state_next = lifeb_pkg::ST_GEN_PRIME;
                end
            end
            lifeb_pkg::ST_RESP:
            begin
                if (!status.out_busy)
                begin
                    state_next = lifeb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lifeb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            lifeb_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.load_req = in_valid;
            end
            lifeb_pkg::ST_ACCESS:
            begin
                cmd.mem_rd_req = !status.is_run;
            end
            lifeb_pkg::ST_CELL_WR:
            begin
                cmd.cell_wr = 1'b1;
            end
            lifeb_pkg::ST_GEN_PRIME:
            begin
                cmd.gen_prime = 1'b1;
            end
            lifeb_pkg::ST_GEN_SWEEP:
            begin
                cmd.gen_step = 1'b1;
            end
            lifeb_pkg::ST_GEN_CHECK:
            begin
                cmd.gen_dec = 1'b1;
            end
            lifeb_pkg::ST_RESP:
            begin
                cmd.out_load = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/lifeb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifeb_dp
// board memory, configuration registers, three-row sweep window with the
// neighbor count logic, generation counter and result register
// ----------------------------------------------------------------------------
module lifeb_dp #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lifeb_pkg::lifeb_cmd_t                cmd,
    output lifeb_pkg::lifeb_status_t             status,
    input  logic [1:0]                           req_type,
    input  logic [5:0]                           row,
    input  logic [5:0]                           col,
    input  logic                                 cell_in,
    input  logic [15:0]                          gen_count,
    input  logic                                 cfg_valid,
    input  logic [lifeb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lifeb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 cell_out,
    output logic                                 addr_error
);

    localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW  = $clog2(MAX_ROWS + 2);
    localparam int RXW = (PW > lifeb_pkg::CFG_DATA_W) ? PW : lifeb_pkg::CFG_DATA_W;
    localparam int CXW = lifeb_pkg::CFG_DATA_W;

    // configuration
    logic [CXW-1:0] rows_used_reg;
    logic [CXW-1:0] cols_used_reg;
    logic [RXW-1:0] rows_wide;
    logic [PW-1:0]  rows_eff;
    logic [CXW-1:0] cols_eff;
    logic [MAX_COLS-1:0] col_mask;

    // latched request
    logic [1:0]  req_type_reg;
    logic [5:0]  row_reg;
    logic [5:0]  col_reg;
    logic        cell_in_reg;
    logic [15:0] gen_cnt_reg;
    logic        req_is_read;
    logic        req_is_write;
    logic        addr_err;
    logic [AW-1:0] req_addr;
    logic [CW-1:0] col_idx;

    // board memory
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic [MAX_COLS-1:0] rd_q_reg;
    logic                rd_valid_reg;
    logic [MAX_COLS-1:0] rd_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [MAX_COLS-1:0] wr_data;
    logic [MAX_COLS-1:0] cell_row;

    // sweep
    logic [PW-1:0]       ptr_reg;
    logic [MAX_COLS-1:0] up_reg;
    logic [MAX_COLS-1:0] me_reg;
    logic                changed_reg;
    logic [MAX_COLS-1:0] dn_in;
    logic                sweep_wr;
    logic [MAX_COLS-1:0] up_m;
    logic [MAX_COLS-1:0] me_m;
    logic [MAX_COLS-1:0] dn_m;
    logic [MAX_COLS-1:0] alive;
    logic [MAX_COLS-1:0] new_row;

    // result register
    logic out_valid_reg;
    logic cell_out_reg;
    logic addr_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= CXW'(40);
            cols_used_reg <= CXW'(40);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == lifeb_pkg::REG_ROWS_USED)
            begin
                rows_used_reg <= cfg_data;
            end
            if (cfg_index == lifeb_pkg::REG_COLS_USED)
            begin
                cols_used_reg <= cfg_data;
            end
        end
    end

    // zero acts as one, anything above the board size as the board size
    always_comb
    begin
        rows_wide = RXW'(rows_used_reg);
        if (rows_wide == '0)
        begin
            rows_wide = RXW'(1);
        end
        if (rows_wide > RXW'(MAX_ROWS))
        begin
            rows_wide = RXW'(MAX_ROWS);
        end
        rows_eff = PW'(rows_wide);

        cols_eff = cols_used_reg;
        if (cols_eff == '0)
        begin
            cols_eff = CXW'(1);
        end
        if (cols_eff > CXW'(MAX_COLS))
        begin
            cols_eff = CXW'(MAX_COLS);
        end

        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = (CXW'(c) < cols_eff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            row_reg      <= row;
            col_reg      <= col;
            cell_in_reg  <= cell_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            gen_cnt_reg <= gen_count;
        end
        else if (cmd.gen_dec)
        begin
            gen_cnt_reg <= gen_cnt_reg - 16'd1;
        end
    end

    assign req_is_read  = (req_type_reg == lifeb_pkg::REQ_READ);
    assign req_is_write = (req_type_reg == lifeb_pkg::REQ_WRITE);
    assign addr_err     = (RXW'(row_reg) >= rows_wide) || (CXW'(col_reg) >= cols_eff);
    assign req_addr     = AW'(row_reg);
    assign col_idx      = CW'(col_reg);

    // memory ports
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = req_addr;
        if (cmd.mem_rd_req)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.gen_prime)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        else if (cmd.gen_step)
        begin
            rd_en   = (ptr_reg < rows_eff);
            rd_addr = AW'(ptr_reg);
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

    always_comb
    begin
        cell_row          = rd_data;
        cell_row[col_idx] = cell_in_reg;
    end

    assign sweep_wr = cmd.gen_step && (ptr_reg >= PW'(2));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = req_addr;
        wr_data = cell_row;
        if (cmd.cell_wr)
        begin
            wr_en = req_is_write && !addr_err;
        end
        else if (sweep_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(ptr_reg - PW'(2));
            wr_data = new_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // rows never written since reset read as dead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // neighbor count on the window: up, me and the row arriving from memory
    assign dn_in = (ptr_reg <= rows_eff) ? rd_data : '0;
    assign up_m  = up_reg & col_mask;
    assign me_m  = me_reg & col_mask;
    assign dn_m  = dn_in & col_mask;

    always_comb
    begin
        logic [MAX_COLS-1:0] p_ul;
        logic [MAX_COLS-1:0] p_ur;
        logic [MAX_COLS-1:0] p_ml;
        logic [MAX_COLS-1:0] p_mr;
        logic [MAX_COLS-1:0] p_dl;
        logic [MAX_COLS-1:0] p_dr;
        logic [3:0]          cnt;
        p_ul = (up_m << 1) & col_mask;
        p_ur = up_m >> 1;
        p_ml = (me_m << 1) & col_mask;
        p_mr = me_m >> 1;
        p_dl = (dn_m << 1) & col_mask;
        p_dr = dn_m >> 1;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            cnt = 4'(p_ul[c]) + 4'(up_m[c]) + 4'(p_ur[c]) + 4'(p_ml[c])
                + 4'(p_mr[c]) + 4'(p_dl[c]) + 4'(dn_m[c]) + 4'(p_dr[c]);
            alive[c] = col_mask[c] && ((cnt == lifeb_pkg::BIRTH_COUNT)
                       || ((cnt == lifeb_pkg::SURVIVE_COUNT) && me_m[c]));
        end
    end

    // cells beyond the used columns keep their values
    assign new_row = (me_reg & ~col_mask) | alive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            changed_reg <= 1'b0;
        end
        else if (cmd.gen_prime)
        begin
            ptr_reg     <= PW'(1);
            changed_reg <= 1'b0;
        end
        else if (cmd.gen_step)
        begin
            ptr_reg <= ptr_reg + PW'(1);
            if (sweep_wr && (new_row != me_reg))
            begin
                changed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gen_prime)
        begin
            up_reg <= '0;
            me_reg <= '0;
        end
        else if (cmd.gen_step)
        begin
            up_reg <= me_reg;
            me_reg <= dn_in;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            cell_out_reg   <= req_is_read && !addr_err && rd_data[col_idx];
            addr_error_reg <= (req_is_read || req_is_write) && addr_err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_out   = cell_out_reg;
    assign addr_error = addr_error_reg;

    assign status.is_run     = (req_type_reg == lifeb_pkg::REQ_RUN);
    assign status.is_write   = req_is_write;
    assign status.gen_zero   = (gen_cnt_reg == 16'd0);
    assign status.gen_last   = (gen_cnt_reg == 16'd1);
    assign status.sweep_last = (ptr_reg == rows_eff + PW'(1));
    assign status.changed    = changed_reg;
    assign status.out_busy   = out_valid_reg && out_stall;

endmodule

// ===== sv/life_automaton_board_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_board_engine_top
// bounded game of life board (born on 3, survives on 2 or 3) with cell
// write, cell read and multi-generation run requests
// ----------------------------------------------------------------------------
// usage
//   input channel: one item per request (req_type, row, col, cell_in,
//   gen_count), taken when in_valid is high and in_stall is low
//   output channel: exactly one item per request (cell_out, addr_error),
//   taken when out_valid is high and out_stall is low
//   config channel: cfg_index 0 is rows_used, 1 is cols_used; cfg_ready is
//   always high, write only while no request is in flight
// sequencing
//   write: access, cell write and response states after accept; read and
//   idle codes: access and response states; run: access, then a prime, a
//   sweep and a check state for each generation actually swept, then response;
//   each sweep streams the board through the single memory read port
//   one row per cycle, rows being rows_used after clipping to 1..MAX_ROWS,
//   and takes a drain step after the last row; the run ends early once a
//   generation changes no cell
//   one item is worked on at a time; the next is accepted in the cycle after
//   the result moves into the output register
// reset
//   board reads as all dead (per-row valid bits), rows_used and cols_used
//   return to 40, no item pending; no clearing pass is needed
// stall
//   a held result keeps its values; a finished item waits in the response
//   state until the output register frees, the input side stalls meanwhile
// ----------------------------------------------------------------------------
module life_automaton_board_engine_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       req_type,
    input  logic [5:0]                       row,
    input  logic [5:0]                       col,
    input  logic                             cell_in,
    input  logic [15:0]                      gen_count,

    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             cell_out,
    output logic                             addr_error,

    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lifeb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lifeb_pkg::CFG_DATA_W-1:0] cfg_data
);

    lifeb_pkg::lifeb_cmd_t    cmd;
    lifeb_pkg::lifeb_status_t status;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: owns the handshake on the request side
    lifeb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // board storage, sweep logic and the result register
    lifeb_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .req_type   (req_type),
        .row        (row),
        .col        (col),
        .cell_in    (cell_in),
        .gen_count  (gen_count),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_out   (cell_out),
        .addr_error (addr_error)
    );

endmodule
